FILE: hw/rtl/ddc_pkg.sv
// ----------------------------------------------------------------------------
// ddc_pkg
// shared types, constants and the crc-16 byte step for the datagram deframer
// ----------------------------------------------------------------------------
`default_nettype none

package ddc_pkg;

  localparam int unsigned HeaderBytes  = 4;
  localparam int unsigned LengthOffset = 2;
  localparam int unsigned HdrWordBytes = 4;

  localparam logic [15:0] CrcSeed = 16'h1D0F;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] MaxPayloadRst = 8'hFF;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC_LO,
    PH_CRC_HI
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_CRC_LO,
    KIND_END,
    KIND_REJECT,
    KIND_IGNORED
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_CRC_BAD,
    ST_TOO_LONG
  } status_e;

  typedef struct packed {
    kind_e       byte_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [31:0] header_word;
    logic [7:0]  frame_length;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  // msb-first crc-16 over one byte, no reflection
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ddc_in_reg.sv
// ----------------------------------------------------------------------------
// ddc_in_reg
// input register stage, takes a new item when empty or whenever the held one moves on
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_in_reg (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  valid_i,
  output logic                 ready_o,
  input  wire ddc_pkg::item_t  item_i,
  input  wire                  take_i,
  output logic                 valid_o,
  output ddc_pkg::item_t       item_o
);

  logic           valid_d, valid_q;
  ddc_pkg::item_t item_q;
  logic           load;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ddc_deframer.sv
// ----------------------------------------------------------------------------
// ddc_deframer
// frame state machine, header collect, payload index and crc check
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_deframer (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  fire_i,
  input  wire ddc_pkg::item_t  item_i,
  input  wire [7:0]            max_payload_i,
  output ddc_pkg::result_t     result_o
);

  ddc_pkg::phase_e phase_d, phase_q;
  logic [7:0]      cnt_d, cnt_q;
  logic [15:0]     crc_d, crc_q;
  logic [31:0]     hdr_d, hdr_q;
  logic [7:0]      len_d, len_q;
  logic [7:0]      crclo_d, crclo_q;

  // values as seen by this item, after a restart
  ddc_pkg::phase_e ph;
  logic [7:0]      cnt;
  logic [15:0]     crc;
  logic [31:0]     hdr;
  logic [7:0]      len;
  logic [7:0]      crclo;

  logic [7:0]      b;
  logic [31:0]     hdr_new;
  logic [7:0]      len_new;
  logic [15:0]     crc_new;
  logic [8:0]      cnt_inc;
  logic            hdr_last;
  logic            pay_last;
  logic            too_long;
  logic [15:0]     rx_crc;

  assign b = item_i.data_byte;

  always_comb begin
    if (item_i.frame_start) begin
      ph    = ddc_pkg::PH_HEADER;
      cnt   = '0;
      crc   = ddc_pkg::CrcSeed;
      hdr   = '0;
      len   = '0;
      crclo = '0;
    end else begin
      ph    = phase_q;
      cnt   = cnt_q;
      crc   = crc_q;
      hdr   = hdr_q;
      len   = len_q;
      crclo = crclo_q;
    end
  end

  always_comb begin
    hdr_new = hdr;
    for (int i = 0; i < ddc_pkg::HdrWordBytes; i++) begin
      if (cnt == 8'(i)) begin
        hdr_new[8*i +: 8] = hdr[8*i +: 8] | b;
      end
    end
  end

  assign len_new  = (cnt == 8'(ddc_pkg::LengthOffset)) ? b : len;
  assign crc_new  = ddc_pkg::crc16_byte(crc, b);
  assign cnt_inc  = {1'b0, cnt} + 9'd1;
  assign hdr_last = cnt_inc >= 9'(ddc_pkg::HeaderBytes);
  assign pay_last = cnt_inc >= {1'b0, len};
  assign too_long = len_new > max_payload_i;
  assign rx_crc   = {b, crclo};

  // next state
  always_comb begin
    phase_d = ph;
    cnt_d   = cnt;
    crc_d   = crc;
    hdr_d   = hdr;
    len_d   = len;
    crclo_d = crclo;
    case (ph)
      ddc_pkg::PH_HEADER: begin
        hdr_d = hdr_new;
        len_d = len_new;
        crc_d = crc_new;
        if (hdr_last) begin
          cnt_d = '0;
          if (too_long) begin
            phase_d = ddc_pkg::PH_IDLE;
          end else if (len_new != 8'd0) begin
            phase_d = ddc_pkg::PH_PAYLOAD;
          end else begin
            phase_d = ddc_pkg::PH_CRC_LO;
          end
        end else begin
          cnt_d = cnt_inc[7:0];
        end
      end
      ddc_pkg::PH_PAYLOAD: begin
        crc_d = crc_new;
        if (pay_last) begin
          cnt_d   = '0;
          phase_d = ddc_pkg::PH_CRC_LO;
        end else begin
          cnt_d = cnt_inc[7:0];
        end
      end
      ddc_pkg::PH_CRC_LO: begin
        crclo_d = b;
        phase_d = ddc_pkg::PH_CRC_HI;
      end
      ddc_pkg::PH_CRC_HI: begin
        cnt_d   = '0;
        phase_d = ddc_pkg::PH_IDLE;
      end
      default: begin
        phase_d = ddc_pkg::PH_IDLE;
      end
    endcase
  end

  // result fields
  always_comb begin
    result_o = '0;
    case (ph)
      ddc_pkg::PH_HEADER: begin
        result_o.byte_kind = ddc_pkg::KIND_HEADER;
        if (hdr_last && too_long) begin
          result_o.byte_kind    = ddc_pkg::KIND_REJECT;
          result_o.header_word  = hdr_new;
          result_o.frame_length = len_new;
          result_o.computed_crc = crc_new;
          result_o.status       = ddc_pkg::ST_TOO_LONG;
        end
      end
      ddc_pkg::PH_PAYLOAD: begin
        result_o.byte_kind     = ddc_pkg::KIND_PAYLOAD;
        result_o.payload_byte  = b;
        result_o.payload_index = cnt;
      end
      ddc_pkg::PH_CRC_LO: begin
        result_o.byte_kind = ddc_pkg::KIND_CRC_LO;
      end
      ddc_pkg::PH_CRC_HI: begin
        result_o.byte_kind    = ddc_pkg::KIND_END;
        result_o.header_word  = hdr;
        result_o.frame_length = len;
        result_o.computed_crc = crc;
        result_o.received_crc = rx_crc;
        result_o.status       = (rx_crc == crc) ? ddc_pkg::ST_OK : ddc_pkg::ST_CRC_BAD;
      end
      default: begin
        result_o.byte_kind = ddc_pkg::KIND_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ddc_pkg::PH_IDLE;
      cnt_q   <= '0;
      crc_q   <= ddc_pkg::CrcSeed;
      hdr_q   <= '0;
      len_q   <= '0;
      crclo_q <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      hdr_q   <= hdr_d;
      len_q   <= len_d;
      crclo_q <= crclo_d;
    end
  end

  a_payload_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ddc_pkg::PH_PAYLOAD |-> len_q != 8'd0 && cnt_q < len_q)
    else $error("payload counter out of range");

  a_header_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ddc_pkg::PH_HEADER |-> cnt_q < 8'(ddc_pkg::HeaderBytes))
    else $error("header counter out of range");

  a_end_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (result_o.byte_kind == ddc_pkg::KIND_END ||
               result_o.byte_kind == ddc_pkg::KIND_REJECT) |=> phase_q == ddc_pkg::PH_IDLE)
    else $error("frame end did not return to idle");

  a_reject_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.byte_kind == ddc_pkg::KIND_REJECT |-> result_o.frame_length > max_payload_i)
    else $error("reject without length over capacity");

endmodule

`default_nettype wire

FILE: hw/rtl/ddc_out_reg.sv
// ----------------------------------------------------------------------------
// ddc_out_reg
// result register, holds a finished result until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module ddc_out_reg (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    load_i,
  input  wire ddc_pkg::result_t  result_i,
  output logic                   can_load_o,
  output logic                   valid_o,
  input  wire                    ready_i,
  output ddc_pkg::result_t       result_o
);

  logic             valid_d, valid_q;
  ddc_pkg::result_t result_q;

  assign can_load_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: hw/rtl/datagram_deframer_crc_check_core.sv
// ----------------------------------------------------------------------------
// datagram_deframer_crc_check_core
// byte-wide deframer for length-framed datagrams with crc-16 check
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: data_byte, tuser: frame_start
// m_axis    out  m_axis_tvalid/tready        tdata: result fields, tuser: byte_kind
// cfg       in   cfg_valid_i/cfg_ready_o     cfg_data_i: max_payload
//
// one item per cycle sustained while the sink takes results; an item passes
// from the input register through the crc step and frame logic into the
// result register. cfg is always ready. reset puts the deframer outside
// any frame with max_payload at 255. a stalled sink holds the result register
// and the input register still takes one more item.
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_deframer_crc_check_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire [0:0]   s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [47:16] header_word,
  // [55:48] frame_length, [71:56] computed_crc, [87:72] received_crc,
  // [89:88] status, [95:90] zero
  output logic [95:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire [7:0]   cfg_data_i
);

  logic [7:0]       max_payload_q;
  ddc_pkg::item_t   in_item;
  ddc_pkg::item_t   held_item;
  logic             held_valid;
  logic             can_load;
  logic             fire;
  ddc_pkg::result_t next_result;
  ddc_pkg::result_t out_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= ddc_pkg::MaxPayloadRst;
    end else if (cfg_valid_i) begin
      max_payload_q <= cfg_data_i;
    end
  end

  assign in_item.data_byte   = s_axis_tdata;
  assign in_item.frame_start = s_axis_tuser[0];
  assign fire                = held_valid && can_load;

  ddc_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .take_i  (fire),
    .valid_o (held_valid),
    .item_o  (held_item)
  );

  ddc_deframer u_deframer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .item_i        (held_item),
    .max_payload_i (max_payload_q),
    .result_o      (next_result)
  );

  ddc_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (fire),
    .result_i   (next_result),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .result_o   (out_result)
  );

  assign m_axis_tuser = out_result.byte_kind;
  assign m_axis_tdata = {6'd0,
                         out_result.status,
                         out_result.received_crc,
                         out_result.computed_crc,
                         out_result.frame_length,
                         out_result.header_word,
                         out_result.payload_index,
                         out_result.payload_byte};

endmodule

`default_nettype wire
